### hdl/category_window_average_assert.svh
// assertion macros shared by the category window average modules
`ifndef CATEGORY_WINDOW_AVERAGE_ASSERT_SVH
`define CATEGORY_WINDOW_AVERAGE_ASSERT_SVH

// condition holds at every edge outside reset
`define CWA_ASSERT_HOLDS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define CWA_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the following cycle
`define CWA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/cwa_pkg.sv
// types and constants of the category window average block
package cwa_pkg;

    localparam int VAL_W  = 47;
    localparam int TOT_W  = 51;
    localparam int FILL_OUT_W = 5;
    localparam int CAT_W  = 3;
    localparam int LIVE_W = 48;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic                     command;
        logic [CAT_W-1:0]         category;
        logic signed [LIVE_W-1:0] live_bytes;
    } cwa_in_t;

    typedef struct packed {
        logic [CAT_W-1:0]      category_out;
        logic [VAL_W-1:0]      category_average;
        logic                  sample_done;
        logic [TOT_W-1:0]      total_average;
        logic [TOT_W-1:0]      total_peak;
        logic [FILL_OUT_W-1:0] fill_count;
    } cwa_out_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_TOTAL,
        ST_CDIV,
        ST_CWAIT,
        ST_TDIV,
        ST_TWAIT,
        ST_FINISH
    } cwa_state_t;

    typedef struct packed {
        logic load;
        logic clr;
        logic upd;
        logic tot;
        logic div_start;
        logic div_tot;
        logic cat_avg_ld;
        logic tot_avg_ld;
        logic out_ld;
    } cwa_cmd_t;

    typedef struct packed {
        logic in_clear;
        logic in_ok;
        logic last;
        logic clr_last;
        logic div_busy;
    } cwa_stat_t;

endpackage

### hdl/cwa_ram.sv
// generic simple dual port ram with registered read
module cwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/cwa_div.sv
// iterative unsigned divider, two quotient bits per cycle
module cwa_div #(
    parameter int DVD_W = 55,
    parameter int DVS_W = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DVD_W-1:0] quotient
);

    localparam int PAD_W = DVD_W + (DVD_W % 2);
    localparam int STEPS = PAD_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [PAD_W-1:0] q_reg;
    logic [PAD_W-1:0] q_next;
    logic [DVS_W-1:0] r_reg;
    logic [DVS_W-1:0] r_next;
    logic [DVS_W-1:0] d_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W:0]   r_wide;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        r_wide = '0;
        for (int i = 0; i < 2; i++) begin
            r_wide = {r_next, q_next[PAD_W-1]};
            q_next = {q_next[PAD_W-2:0], 1'b0};
            if (r_wide >= {1'b0, d_reg}) begin
                r_wide    = r_wide - {1'b0, d_reg};
                q_next[0] = 1'b1;
            end
            r_next = r_wide[DVS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNT_W'(STEPS);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= PAD_W'(dividend);
            r_reg <= '0;
            d_reg <= divisor;
        end else if (cnt_reg != '0) begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = q_reg[DVD_W-1:0];

endmodule

### hdl/cwa_dp.sv
// datapath: window memories, running sums, divider and result register
module cwa_dp
    import cwa_pkg::*;
#(
    parameter int NUM_CATEGORIES = 8,
    parameter int WINDOW_SLOTS   = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  cwa_cmd_t  cmd,
    output cwa_stat_t st,
    input  cwa_in_t   s_data,
    output cwa_out_t  m_data
);

`include "category_window_average_assert.svh"

    localparam int POS_W     = WINDOW_SLOTS > 1 ? $clog2(WINDOW_SLOTS) : 1;
    localparam int IDX_W     = NUM_CATEGORIES > 1 ? $clog2(NUM_CATEGORIES) : 1;
    localparam int CAT_ROWS  = NUM_CATEGORIES > 1 ? NUM_CATEGORIES : 2;
    localparam int CAT_DEPTH = CAT_ROWS * (1 << POS_W);
    localparam int TOT_DEPTH = 1 << POS_W;
    localparam int CA_W      = IDX_W + POS_W;
    localparam int CSUM_W    = VAL_W + $clog2(WINDOW_SLOTS);
    localparam int TSUM_W    = TOT_W + $clog2(WINDOW_SLOTS);
    localparam int FILL_W    = $clog2(WINDOW_SLOTS + 1);
    localparam int TOT_W1    = TOT_W + 1;

    logic [CAT_W-1:0]  cat_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [CSUM_W-1:0] sums_reg [NUM_CATEGORIES];
    logic [CSUM_W-1:0] csum_next;
    logic [TOT_W-1:0]  sample_reg;
    logic [TOT_W-1:0]  sample_next;
    logic [TOT_W1-1:0] sample_wide;
    logic [TSUM_W-1:0] tsum_reg;
    logic [TSUM_W-1:0] tsum_next;
    logic [TOT_W-1:0]  peak_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [FILL_W-1:0] filled_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [CA_W-1:0]   sweep_reg;
    logic [VAL_W-1:0]  cat_avg_reg;
    logic [TOT_W-1:0]  tot_avg_reg;
    cwa_out_t          m_data_reg;

    logic [IDX_W-1:0]  idx;
    logic [CA_W-1:0]   cat_addr;
    logic              cat_we;
    logic [CA_W-1:0]   cat_waddr;
    logic [VAL_W-1:0]  cat_wdata;
    logic [VAL_W-1:0]  cat_rdata;
    logic              tot_we;
    logic [POS_W-1:0]  tot_waddr;
    logic [TOT_W-1:0]  tot_wdata;
    logic [TOT_W-1:0]  tot_rdata;
    logic [TSUM_W-1:0] div_dividend;
    logic [TSUM_W-1:0] div_quot;
    logic              div_busy;

    assign idx      = IDX_W'(cat_reg);
    assign cat_addr = {idx, pos_reg};

    // clearing pass writes zeros through both memories
    assign cat_we    = cmd.clr | cmd.upd;
    assign cat_waddr = cmd.clr ? sweep_reg : cat_addr;
    assign cat_wdata = cmd.clr ? '0 : val_reg;
    assign tot_we    = cmd.clr | cmd.tot;
    assign tot_waddr = cmd.clr ? sweep_reg[POS_W-1:0] : pos_reg;
    assign tot_wdata = cmd.clr ? '0 : sample_reg;

    cwa_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAT_DEPTH)
    ) u_cat_ram (
        .aclk  (aclk),
        .we    (cat_we),
        .waddr (cat_waddr),
        .wdata (cat_wdata),
        .raddr (cat_addr),
        .rdata (cat_rdata)
    );

    cwa_ram #(
        .WIDTH (TOT_W),
        .DEPTH (TOT_DEPTH)
    ) u_tot_ram (
        .aclk  (aclk),
        .we    (tot_we),
        .waddr (tot_waddr),
        .wdata (tot_wdata),
        .raddr (pos_reg),
        .rdata (tot_rdata)
    );

    assign div_dividend = cmd.div_tot ? tsum_reg : TSUM_W'(sums_reg[idx]);

    cwa_div #(
        .DVD_W (TSUM_W),
        .DVS_W (FILL_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (fill_reg),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    always_comb begin
        csum_next   = sums_reg[idx] - CSUM_W'(cat_rdata) + CSUM_W'(val_reg);
        sample_wide = {1'b0, sample_reg} + TOT_W1'(val_reg);
        // sample total saturates at the full 51-bit value
        sample_next = sample_wide[TOT_W] ? '1 : sample_wide[TOT_W-1:0];
        tsum_next   = tsum_reg - TSUM_W'(tot_rdata) + TSUM_W'(sample_reg);
        fill_next   = (32'(filled_reg) < WINDOW_SLOTS) ? filled_reg + 1'b1
                                                       : FILL_W'(WINDOW_SLOTS);
        pos_next    = (32'(pos_reg) == WINDOW_SLOTS - 1) ? '0 : pos_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg  <= '0;
            pos_reg    <= '0;
            filled_reg <= '0;
        end else begin
            sweep_reg <= cmd.clr ? sweep_reg + 1'b1 : '0;
            if (cmd.clr) begin
                pos_reg    <= '0;
                filled_reg <= '0;
            end else if (cmd.tot) begin
                pos_reg    <= pos_next;
                filled_reg <= fill_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cat_reg <= s_data.category;
            val_reg <= s_data.live_bytes[LIVE_W-1] ? '0 : s_data.live_bytes[VAL_W-1:0];
        end
        if (cmd.clr) begin
            for (int c = 0; c < NUM_CATEGORIES; c++) begin
                sums_reg[c] <= '0;
            end
            sample_reg <= '0;
            tsum_reg   <= '0;
            peak_reg   <= '0;
        end else if (cmd.upd) begin
            sums_reg[idx] <= csum_next;
            sample_reg    <= sample_next;
            fill_reg      <= fill_next;
        end else if (cmd.tot) begin
            tsum_reg   <= tsum_next;
            sample_reg <= '0;
            if (sample_reg > peak_reg) begin
                peak_reg <= sample_reg;
            end
        end
        if (cmd.cat_avg_ld) begin
            cat_avg_reg <= div_quot[VAL_W-1:0];
        end
        if (cmd.tot_avg_ld) begin
            tot_avg_reg <= div_quot[TOT_W-1:0];
        end
        if (cmd.out_ld) begin
            m_data_reg.category_out     <= cat_reg;
            m_data_reg.category_average <= cat_avg_reg;
            m_data_reg.sample_done      <= st.last;
            m_data_reg.total_average    <= st.last ? tot_avg_reg : '0;
            m_data_reg.total_peak       <= st.last ? peak_reg : '0;
            m_data_reg.fill_count       <= FILL_OUT_W'(fill_reg);
        end
    end

    assign st.in_clear = (s_data.command == CMD_CLEAR);
    assign st.in_ok    = (32'(s_data.category) < NUM_CATEGORIES);
    assign st.last     = (32'(cat_reg) == NUM_CATEGORIES - 1);
    assign st.clr_last = (sweep_reg == CA_W'(CAT_DEPTH - 1));
    assign st.div_busy = div_busy;
    assign m_data      = m_data_reg;

    `CWA_ASSERT_HOLDS(a_pos_range, aclk, aresetn, 32'(pos_reg) < WINDOW_SLOTS)
    `CWA_ASSERT_HOLDS(a_filled_range, aclk, aresetn, 32'(filled_reg) <= WINDOW_SLOTS)
    `CWA_ASSERT_NEXT(a_ring_wraps_full, aclk, aresetn, cmd.tot && pos_reg == '0 && filled_reg != '0, 32'(filled_reg) == WINDOW_SLOTS)

endmodule

### hdl/cwa_ctrl.sv
// controller: sequences clearing, window update, divisions and result handoff
module cwa_ctrl
    import cwa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  cwa_stat_t st,
    output cwa_cmd_t  cmd
);

`include "category_window_average_assert.svh"

    cwa_state_t state_reg;
    cwa_state_t state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr = 1'b1;
                if (st.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    if (st.in_clear) begin
                        state_next = ST_CLEAR;
                    end else if (st.in_ok) begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.upd    = 1'b1;
                state_next = st.last ? ST_TOTAL : ST_CDIV;
            end
            ST_TOTAL: begin
                cmd.tot    = 1'b1;
                state_next = ST_CDIV;
            end
            ST_CDIV: begin
                cmd.div_start = 1'b1;
                state_next    = ST_CWAIT;
            end
            ST_CWAIT: begin
                if (!st.div_busy) begin
                    cmd.cat_avg_ld = 1'b1;
                    state_next     = st.last ? ST_TDIV : ST_FINISH;
                end
            end
            ST_TDIV: begin
                cmd.div_start = 1'b1;
                cmd.div_tot   = 1'b1;
                state_next    = ST_TWAIT;
            end
            ST_TWAIT: begin
                cmd.div_tot = 1'b1;
                if (!st.div_busy) begin
                    cmd.tot_avg_ld = 1'b1;
                    state_next     = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // wait until the result register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.out_ld = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign m_valid_next = cmd.out_ld ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    assign m_valid      = m_valid_reg;

    `CWA_ASSERT_IMPL(a_div_start_idle, aclk, aresetn, cmd.div_start, !st.div_busy)
    `CWA_ASSERT_NEXT(a_clear_word, aclk, aresetn, s_valid && s_ready && st.in_clear, state_reg == ST_CLEAR)
    `CWA_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, cmd.out_ld && m_valid_reg, m_ready)

endmodule

### hdl/category_window_average.sv
// category window average top level
// Per-category sliding-window average of live byte counts. Send one sample
// word per category (0 .. NUM_CATEGORIES-1, ascending); each returns one
// result word with the category's window average, and the last category's
// word also carries the total average and peak. A clear word (command 1)
// returns nothing. After reset and after every clear word the block sweeps
// zeros through its window memories and takes no word meanwhile. Each word
// passes once through the shared divider, which retires two quotient bits a
// cycle over the widened total-sum width; the word that closes a sample adds
// a total update step and a second divider start and pass. A new word is
// taken while a finished result still waits in the output register.
module category_window_average
    import cwa_pkg::*;
#(
    parameter int NUM_CATEGORIES = 8,
    parameter int WINDOW_SLOTS   = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  cwa_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output cwa_out_t m_data
);

    cwa_cmd_t  cmd;
    cwa_stat_t st;

    cwa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    cwa_dp #(
        .NUM_CATEGORIES (NUM_CATEGORIES),
        .WINDOW_SLOTS   (WINDOW_SLOTS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .st      (st),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule
